### rtl/ttc_pkg.sv
// Shared item types and fixed constants of the threshold trigger capture block.
package ttc_pkg;

    localparam logic       CMD_SAMPLE  = 1'b0;
    localparam logic       CMD_READ    = 1'b1;
    localparam logic       KIND_DONE   = 1'b0;
    localparam logic       KIND_READ   = 1'b1;
    localparam logic [9:0] C_THRESHOLD_RESET = 10'd700;

    typedef struct packed {
        logic        command;
        logic [9:0]  ch0_sample;
        logic [9:0]  ch1_sample;
        logic [9:0]  ch2_sample;
        logic [9:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [9:0]  ch0_out;
        logic [9:0]  ch1_out;
        logic [9:0]  ch2_out;
        logic        window_valid;
        logic [31:0] detections;
        logic [10:0] post_trigger_target;
    } t_out_item;

endpackage

### rtl/threshold_trigger_capture.sv
// Top level of the threshold trigger capture block: ring, trigger control and window readout.

// The block takes one item per clock cycle on its input channel as long as the output side
// keeps up. A sample item is written into the active half of a two-bank sample memory that
// serves as the pretrigger ring; when a capture completes, the roles of the two banks swap,
// so the frozen window is in place at once and no copy is made. A read item looks up the
// frozen bank through the memory's single registered read port; its result then moves
// through the result stage and the output register, as does a capture-complete result. The
// only pause comes from the output: one result can wait in the output register and one in
// the stage behind it, and the input is stalled only when both are held. There is no
// clearing pass after reset, and the window is readable only after the first capture.
module threshold_trigger_capture #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int CHANNELS     = 3,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  ttc_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ttc_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import ttc_pkg::*;

    localparam int AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW     = $clog2(WINDOW_DEPTH + 1);
    localparam int STORED = (CHANNELS < 3) ? CHANNELS : 3;
    localparam int MW     = STORED * SAMPLE_BITS;
    localparam int XMAX   = WINDOW_DEPTH - 1 + 1023;
    localparam int XW     = $clog2(XMAX + 1);
    localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    // Reduces a sum below XMAX + 1 modulo the window depth by conditional subtraction
    // of shifted copies of the depth.
    function automatic logic [AW-1:0] mod_depth(input logic [XW-1:0] x_in);
        logic [XW-1:0] x;
        x = x_in;
        for (int k = 10; k >= 0; k--) begin
            if ((WINDOW_DEPTH << k) <= XMAX) begin
                if (x >= XW'(WINDOW_DEPTH << k)) begin
                    x = x - XW'(WINDOW_DEPTH << k);
                end
            end
        end
        return x[AW-1:0];
    endfunction

    // Control state.
    logic [9:0]    r_threshold;
    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_trig, n_trig;
    logic [FW-1:0] r_post, n_post;
    logic [31:0]   r_det, n_det;
    logic [10:0]   r_span, n_span;
    logic          r_present, n_present;
    logic [AW-1:0] r_base, n_base;
    logic          r_bank;   // bank that currently holds the ring

    // Sample memory: two banks, one written as the ring, the other read as the window.
    logic [MW-1:0] r_mem [2][WINDOW_DEPTH];
    logic [MW-1:0] r_rd_data;

    // Result stage behind the memory read and the output register.
    logic          r_s1_valid;
    logic          r_s1_use_mem;
    t_out_item     r_s1_item;
    logic          r_out_valid;
    t_out_item     r_out_item;

    logic          out_free;
    logic          s1_adv;
    logic          in_acc;
    logic          is_read;
    logic          is_sample;
    logic          full;
    logic          over;
    logic          freeze;
    logic [15:0]   s [3];
    logic [MW-1:0] wr_data;
    logic [AW-1:0] wr_addr;
    logic [AW:0]   wr_sum;
    logic [AW-1:0] rd_addr;
    logic [FW-1:0] fill_tmp;
    t_out_item     s1_out;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_read    = in_acc && (i_in_item.command == CMD_READ);
    assign is_sample  = in_acc && (i_in_item.command == CMD_SAMPLE);

    assign s[0] = {6'd0, i_in_item.ch0_sample} & SMASK;
    assign s[1] = {6'd0, i_in_item.ch1_sample} & SMASK;
    assign s[2] = {6'd0, i_in_item.ch2_sample} & SMASK;

    always_comb begin
        wr_data = '0;
        for (int c = 0; c < STORED; c++) begin
            wr_data[c*SAMPLE_BITS +: SAMPLE_BITS] = s[c][SAMPLE_BITS-1:0];
        end
    end

    assign full    = (r_fill >= FW'(WINDOW_DEPTH));
    assign over    = (s[0] > {6'd0, r_threshold}) || (s[1] > {6'd0, r_threshold})
                  || (s[2] > {6'd0, r_threshold});
    assign wr_sum  = (AW+1)'(r_head) + (AW+1)'(r_fill);
    assign rd_addr = mod_depth(XW'(r_base) + XW'(i_in_item.read_index));

    // Next state for a sample item. When the ring is full the oldest entry goes and
    // the new sample takes its slot, which is the old head.
    always_comb begin
        n_head    = r_head;
        n_fill    = r_fill;
        n_trig    = r_trig;
        n_post    = r_post;
        n_det     = r_det;
        n_span    = r_span;
        n_present = r_present;
        n_base    = r_base;
        freeze    = 1'b0;
        fill_tmp  = r_fill;
        wr_addr   = r_head;

        if (r_trig) begin
            if (r_post < FW'(WINDOW_DEPTH)) begin
                n_post = r_post + FW'(1);
            end
        end else if (over) begin
            n_trig = 1'b1;
            n_det  = r_det + 32'd1;
            if (full) begin
                n_span = 11'(WINDOW_DEPTH / 2);
            end else begin
                n_span = 11'(FW'(WINDOW_DEPTH) - r_fill);
            end
        end

        if (full) begin
            n_head   = (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + AW'(1);
            fill_tmp = FW'(WINDOW_DEPTH - 1);
            wr_addr  = r_head;
        end else if (wr_sum >= (AW+1)'(WINDOW_DEPTH)) begin
            wr_addr  = AW'(wr_sum - (AW+1)'(WINDOW_DEPTH));
        end else begin
            wr_addr  = wr_sum[AW-1:0];
        end
        n_fill = fill_tmp + FW'(1);

        // Capture completes: the ring bank becomes the window bank and the ring restarts.
        if (n_post >= FW'(WINDOW_DEPTH / 2) && n_fill >= FW'(WINDOW_DEPTH)) begin
            freeze    = 1'b1;
            n_base    = n_head;
            n_present = 1'b1;
            n_fill    = '0;
            n_trig    = 1'b0;
            n_post    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= C_THRESHOLD_RESET;
            r_head      <= '0;
            r_fill      <= '0;
            r_trig      <= 1'b0;
            r_post      <= '0;
            r_det       <= '0;
            r_span      <= '0;
            r_present   <= 1'b0;
            r_base      <= '0;
            r_bank      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
            if (is_sample) begin
                r_head    <= n_head;
                r_fill    <= n_fill;
                r_trig    <= n_trig;
                r_post    <= n_post;
                r_det     <= n_det;
                r_span    <= n_span;
                r_present <= n_present;
                r_base    <= n_base;
                if (freeze) begin
                    r_bank <= !r_bank;
                end
            end
        end
    end

    // Ring write into the active bank, window read from the other one.
    always_ff @(posedge i_clk) begin
        if (is_sample) begin
            r_mem[r_bank][wr_addr] <= wr_data;
        end
        if (is_read && r_present) begin
            r_rd_data <= r_mem[!r_bank][rd_addr];
        end
    end

    // Result stage. Only read items that find a window take channel data from memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (is_read || (is_sample && freeze)) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_read) begin
            r_s1_use_mem                  <= r_present;
            r_s1_item.result_kind         <= KIND_READ;
            r_s1_item.ch0_out             <= '0;
            r_s1_item.ch1_out             <= '0;
            r_s1_item.ch2_out             <= '0;
            r_s1_item.window_valid        <= r_present;
            r_s1_item.detections          <= r_det;
            r_s1_item.post_trigger_target <= r_span;
        end else if (is_sample && freeze) begin
            r_s1_use_mem                  <= 1'b0;
            r_s1_item.result_kind         <= KIND_DONE;
            r_s1_item.ch0_out             <= '0;
            r_s1_item.ch1_out             <= '0;
            r_s1_item.ch2_out             <= '0;
            r_s1_item.window_valid        <= 1'b1;
            r_s1_item.detections          <= n_det;
            r_s1_item.post_trigger_target <= n_span;
        end
    end

    always_comb begin
        logic [15:0] ch [3];
        for (int c = 0; c < 3; c++) begin
            ch[c] = '0;
        end
        for (int c = 0; c < STORED; c++) begin
            ch[c] = 16'(r_rd_data[c*SAMPLE_BITS +: SAMPLE_BITS]);
        end
        s1_out = r_s1_item;
        if (r_s1_use_mem) begin
            s1_out.ch0_out = ch[0][9:0];
            s1_out.ch1_out = ch[1][9:0];
            s1_out.ch2_out = ch[2][9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_item <= s1_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The ring fill never passes the depth and the head stays inside the ring.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FW'(WINDOW_DEPTH)) && ((AW+1)'(r_head) < (AW+1)'(WINDOW_DEPTH)))
        else $error("ring fill or head out of range");

    // A completed capture leaves an empty, idle ring and a readable window.
    a_freeze_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_sample && freeze) |=> (r_fill == '0) && !r_trig && r_present && r_s1_valid)
        else $error("capture completion did not restart the ring");

    // Post-trigger counting happens only during a capture.
    a_post_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_trig |-> (r_post == '0))
        else $error("post count nonzero outside a capture");

    // A waiting result is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid && $stable(r_out_item))
        else $error("output result changed while stalled");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the threshold trigger capture block.
module testbench;
    import ttc_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int HALF_DEPTH  = DEPTH / 2;
    // The limit leaves a wide margin over the length of a run, even with every item a read
    // under the longest stalls.
    localparam int CYCLE_LIMIT = 60_000;
    // Results pass the result stage and the output register; these idle cycles settle the block.
    localparam int SETTLE      = 8;
    localparam int SHOW_MAX    = 10;

    // One stored entry holds the three channels as {ch0, ch1, ch2}.
    typedef logic [29:0] t_triple;

    // A row of the directed table. Where typed is set, want is the result read straight
    // off the specification; otherwise the result comes from the capture model below.
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       cfg_we   = 1'b0;
    logic [9:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    t_in_item   in_item  = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_item;
    logic       out_stall = 1'b0;

    threshold_trigger_capture DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Capture model state. The ring keeps the pretrigger history; the frozen bank holds
    // the last captured window, read back relative to its oldest entry.
    t_triple     ring_mem   [DEPTH];
    t_triple     frozen_mem [DEPTH];
    int unsigned oldest_pos    = 0;
    int unsigned stored_cnt    = 0;
    int unsigned after_cnt     = 0;
    int unsigned frozen_base   = 0;
    bit          armed         = 1'b0;
    bit          have_window   = 1'b0;
    logic [31:0] trig_count    = '0;
    logic [10:0] span_hold     = '0;
    logic [9:0]  threshold_now = C_THRESHOLD_RESET;

    // Results the block still owes, oldest first.
    t_out_item results_owed [$];

    int unsigned cycle_count     = 0;
    int unsigned items_sent      = 0;
    int unsigned samples_sent    = 0;
    int unsigned reads_sent      = 0;
    int unsigned captures_seen   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned thresholds_set  = 0;

    // Idle pressure on each side, in percent chance that a burst starts.
    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;

    // Advances the capture model by one accepted item. Returns 1 when the item causes a
    // result and places that result in res.
    function automatic bit advance_capture(input t_in_item itm, output t_out_item res);
        bit          produced;
        int unsigned pos;
        produced = 1'b0;
        res      = '0;
        if (itm.command == CMD_READ) begin
            // A read never changes state. Before the first freeze its channels and window flag are zero.
            res.result_kind = KIND_READ;
            if (have_window) begin
                pos = (frozen_base + itm.read_index) % DEPTH;
                {res.ch0_out, res.ch1_out, res.ch2_out} = frozen_mem[pos];
                res.window_valid = 1'b1;
            end
            res.detections          = trig_count;
            res.post_trigger_target = span_hold;
            produced                = 1'b1;
        end else begin
            if (armed) begin
                // The post-trigger count saturates at the full depth.
                if (after_cnt < DEPTH) begin
                    after_cnt++;
                end
            end else if (itm.ch0_sample > threshold_now || itm.ch1_sample > threshold_now ||
                         itm.ch2_sample > threshold_now) begin
                armed = 1'b1;
                trig_count++;
                // The span is judged on the fill before this sample goes in.
                span_hold = (stored_cnt >= DEPTH) ? 11'(HALF_DEPTH) : 11'(DEPTH - stored_cnt);
            end
            // A full ring drops its oldest entry to make room.
            if (stored_cnt >= DEPTH) begin
                oldest_pos = (oldest_pos + 1) % DEPTH;
                stored_cnt = DEPTH - 1;
            end
            ring_mem[(oldest_pos + stored_cnt) % DEPTH] =
                {itm.ch0_sample, itm.ch1_sample, itm.ch2_sample};
            stored_cnt++;
            // Enough post-trigger samples with a full ring freeze the window.
            if (after_cnt >= HALF_DEPTH && stored_cnt >= DEPTH) begin
                frozen_mem  = ring_mem;
                frozen_base = oldest_pos;
                have_window = 1'b1;
                stored_cnt  = 0;
                armed       = 1'b0;
                after_cnt   = 0;
                captures_seen++;
                res.result_kind         = KIND_DONE;
                res.window_valid        = 1'b1;
                res.detections          = trig_count;
                res.post_trigger_target = span_hold;
                produced                = 1'b1;
            end
        end
        return produced;
    endfunction

    function automatic string describe(input t_out_item r);
        return $sformatf("kind=%0d ch=%0d/%0d/%0d window=%0d det=%0d span=%0d",
                         r.result_kind, r.ch0_out, r.ch1_out, r.ch2_out,
                         r.window_valid, r.detections, r.post_trigger_target);
    endfunction

    // Called at a falling edge. Offers one item, possibly after an idle burst, waits for
    // the accepting rising edge, updates the model there and returns at the next falling
    // edge with valid still high, so back-to-back items need no extra assignment.
    task automatic send_item(input t_in_item itm, input bit typed = 1'b0,
                             input t_out_item want = '0);
        t_out_item predicted;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= itm;
        do @(posedge clk); while (in_stall);
        if (advance_capture(itm, predicted)) begin
            results_owed.push_back(typed ? want : predicted);
        end
        items_sent++;
        if (itm.command == CMD_READ) begin
            reads_sent++;
        end else begin
            samples_sent++;
        end
        @(negedge clk);
    endtask

    // Holds the input idle until every owed result has arrived, then lets the block
    // settle, since a sample that causes no result may still be in flight.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (results_owed.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [9:0] value);
        drain_results();
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we        <= 1'b0;
        threshold_now  = value;
        thresholds_set++;
    endtask

    function automatic t_in_item random_read();
        t_in_item itm;
        itm.command    = CMD_READ;
        itm.ch0_sample = 10'($urandom);
        itm.ch1_sample = 10'($urandom);
        itm.ch2_sample = 10'($urandom);
        case ($urandom_range(0, 9))
            0:       itm.read_index = '0;
            1:       itm.read_index = '1;
            default: itm.read_index = 10'($urandom);
        endcase
        return itm;
    endfunction

    // Quiet samples stay at or under the threshold; with the given chance per thousand
    // one channel jumps above it. At the top threshold nothing can trigger, so all
    // channels take the full range.
    function automatic t_in_item random_sample(input int spike_pm);
        t_in_item   itm;
        logic [9:0] peak;
        itm.command    = CMD_SAMPLE;
        itm.read_index = 10'($urandom);
        if (threshold_now == '1) begin
            itm.ch0_sample = 10'($urandom);
            itm.ch1_sample = 10'($urandom);
            itm.ch2_sample = 10'($urandom);
        end else begin
            itm.ch0_sample = 10'($urandom_range(0, threshold_now));
            itm.ch1_sample = 10'($urandom_range(0, threshold_now));
            itm.ch2_sample = 10'($urandom_range(0, threshold_now));
            if ($urandom_range(0, 999) < spike_pm) begin
                peak = 10'($urandom_range(int'(threshold_now) + 1, 1023));
                case ($urandom_range(0, 2))
                    0:       itm.ch0_sample = peak;
                    1:       itm.ch1_sample = peak;
                    default: itm.ch2_sample = peak;
                endcase
            end
        end
        return itm;
    endfunction

    // Streams samples with reads mixed in until one more capture completes or the item
    // cap is hit, then issues 24 reads of the window.
    task automatic capture_round(input int spike_pm, input int max_items, input int read_pct);
        int unsigned start;
        int          n;
        start = captures_seen;
        n     = 0;
        while (captures_seen == start && n < max_items) begin
            if ($urandom_range(0, 99) < read_pct) begin
                send_item(random_read());
            end else begin
                send_item(random_sample(spike_pm));
            end
            n++;
        end
        repeat (24) send_item(random_read());
    endtask

    function automatic t_row sample_row(input logic [9:0] c0, input logic [9:0] c1,
                                        input logic [9:0] c2, input logic [9:0] idx);
        t_row row;
        row.item  = '{command: CMD_SAMPLE, ch0_sample: c0, ch1_sample: c1, ch2_sample: c2,
                      read_index: idx};
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    // Reads issued before any freeze: the result carries zeros and only the counters.
    function automatic t_row read_row(input logic [9:0] idx, input logic [9:0] junk,
                                      input logic [31:0] det, input logic [10:0] span);
        t_row row;
        row.item  = '{command: CMD_READ, ch0_sample: junk, ch1_sample: junk,
                      ch2_sample: junk, read_index: idx};
        row.typed = 1'b1;
        row.want  = '0;
        row.want.result_kind         = KIND_READ;
        row.want.detections          = det;
        row.want.post_trigger_target = span;
        return row;
    endfunction

    // The receiver stalls in bursts that start with the chance stall_pct.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            out_stall  <= 1'b1;
            stall_left  = $urandom_range(0, 5);
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (results_owed.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_MAX) begin
                $display("Cycle %0d: result with nothing owed: %s", cycle_count, describe(got));
            end
        end else begin
            want = results_owed.pop_front();
            results_checked++;
            if (got.result_kind !== want.result_kind || got.ch0_out !== want.ch0_out ||
                got.ch1_out !== want.ch1_out || got.ch2_out !== want.ch2_out ||
                got.window_valid !== want.window_valid ||
                got.detections !== want.detections ||
                got.post_trigger_target !== want.post_trigger_target) begin
                mismatches++;
                if (mismatches <= SHOW_MAX) begin
                    $display("Cycle %0d: result %0d differs", cycle_count, results_checked);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        end
    endtask

    // Outputs are sampled at the rising edge, before the block's own updates land.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results still owed",
                     cycle_count, results_owed.size());
            $display("Simulation FAILED");
            $finish;
        end else if (rst_n && out_valid && !out_stall) begin
            check_result(out_item);
        end
    end

    initial begin
        t_row rows [$];

        // Directed items: reads before any capture, samples at the threshold and above it on
        // each channel, and the field extremes. The trigger lands with two samples stored, so the
        // latched span is the depth minus two.
        rows.push_back(read_row(10'd0, 10'd0, 32'd0, 11'd0));
        rows.push_back(read_row(10'd1023, 10'd1023, 32'd0, 11'd0));
        rows.push_back(sample_row(10'd0, 10'd0, 10'd0, 10'd0));
        rows.push_back(sample_row(10'd700, 10'd700, 10'd700, 10'd1023));
        rows.push_back(read_row(10'd512, 10'd0, 32'd0, 11'd0));
        rows.push_back(sample_row(10'd1023, 10'd0, 10'd0, 10'd0));
        rows.push_back(read_row(10'd1, 10'd0, 32'd1, 11'd1022));
        rows.push_back(sample_row(10'd0, 10'd701, 10'd0, 10'd5));
        rows.push_back(sample_row(10'd0, 10'd0, 10'd1023, 10'd0));
        rows.push_back(sample_row(10'd1023, 10'd1023, 10'd1023, 10'd1023));
        rows.push_back(read_row(10'd1023, 10'd1023, 32'd1, 11'd1022));
        rows.push_back(sample_row(10'd5, 10'd6, 10'd7, 10'd1023));

        // Synchronous reset, released on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gap_pct   = 20;
        stall_pct = 20;
        foreach (rows[k]) begin
            send_item(rows[k].item, rows[k].typed, rows[k].want);
        end

        // The capture armed above keeps counting post-trigger samples. The ring cannot
        // fill within this run, so every read still finds no window.
        capture_round(20, 100, 10);

        // Samples over the full range at the top threshold, with heavy output stalls.
        gap_pct   = 0;
        stall_pct = 35;
        write_threshold(10'h3FF);
        capture_round(0, 80, 10);

        // Threshold zero with spikes on every sample, input gaps only.
        gap_pct   = 25;
        stall_pct = 0;
        write_threshold(10'h000);
        capture_round(1000, 60, 10);

        // A random threshold under light pressure on both sides.
        gap_pct   = 15;
        stall_pct = 15;
        write_threshold(10'($urandom_range(1, 1022)));
        capture_round(5, 40, 10);

        // Closing stretch at full rate on both sides.
        gap_pct   = 0;
        stall_pct = 0;
        write_threshold(C_THRESHOLD_RESET);
        capture_round(10, 40, 8);

        drain_results();
        repeat (SETTLE) @(negedge clk);

        $display("Ran %0d items (%0d samples, %0d reads) under %0d threshold writes",
                 items_sent, samples_sent, reads_sent, thresholds_set);
        $display("Saw %0d window captures; %0d results checked, %0d mismatches",
                 captures_seen, results_checked, mismatches);
        if (mismatches == 0 && results_owed.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
